@@ sv/v3alu_pkg.sv @@
// ----------------------------------------------------------------------------
// v3alu_pkg
// Types and constants for the three-component Q16.16 vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam int DW    = 32;          // fixed-point word width
  localparam int FB    = 16;          // fraction bits
  localparam int OP_W  = 4;           // operation code width
  localparam int SAT_W = 2 * DW + 2;  // width of any exact intermediate
  localparam int DQ_W  = FB + 2;      // normalize quotient bits

  typedef logic signed [DW-1:0] fx_t;

  localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB       = 4'd1;
  localparam logic [OP_W-1:0] OP_SCALE     = 4'd2;
  localparam logic [OP_W-1:0] OP_DOT       = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL       = 4'd4;
  localparam logic [OP_W-1:0] OP_CROSS     = 4'd5;
  localparam logic [OP_W-1:0] OP_NORMALIZE = 4'd6;
  localparam logic [OP_W-1:0] OP_CLAMP     = 4'd7;
  localparam logic [OP_W-1:0] OP_LENGTH    = 4'd8;

  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0] operation;
    fx_t             a_x;
    fx_t             a_y;
    fx_t             a_z;
    fx_t             b_x;
    fx_t             b_y;
    fx_t             b_z;
    fx_t             scale_factor;
    fx_t             clamp_low;
    fx_t             clamp_high;
  } req_t;

  typedef struct packed {
    fx_t  result_x;
    fx_t  result_y;
    fx_t  result_z;
    fx_t  result_scalar;
    logic saturated;
  } rsp_t;

  typedef struct packed {
    logic sat;
    fx_t  val;
  } satv_t;

  // Limit a wide signed value to the word range and flag when limited
  function automatic satv_t fx_sat(input logic signed [SAT_W-1:0] v);
    satv_t r;
    if (v[SAT_W-1:DW-1] != {(SAT_W-DW+1){v[DW-1]}}) begin
      r.sat = 1'b1;
      r.val = v[SAT_W-1] ? FX_MIN : FX_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/vector3_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Pipelined three-component Q16.16 vector ALU with square root and divide.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output side does not stall.
// Every operation goes through the same 29 register stages: operand
// select, six parallel 32x32 multipliers, a combine stage, 16 square-root
// stages (two root bits each) and 9 divide stages (two quotient bits each,
// three components side by side), then the output register. A stall on the
// result side freezes the whole pipeline, so req_ready follows rsp_ready
// while a result is waiting.
module vector3_arithmetic_unit
  import v3alu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SQ_STG  = DW / 2;
  localparam int DIV_STG = DQ_W / 2;
  localparam int NPL     = 1 + SQ_STG + DIV_STG;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    fx_t [2:0]                a;
    rsp_t                     res;
    logic [2*DW-1:0]          n;
    logic [DW+1:0]            rem;
    logic [DW-1:0]            root;
    logic [2:0][DW-1:0]       drem;
    logic [2:0][DQ_W-1:0]     dn;
    logic [2:0][DQ_W-1:0]     dq;
  } pipe_t;

  // One square-root digit: bring in two radicand bits, try the next root bit
  function automatic pipe_t sqrt_step(input pipe_t p);
    pipe_t          r;
    logic [DW+2:0]  r2;
    logic [DW+2:0]  t;
    r  = p;
    r2 = {p.rem[DW:0], p.n[2*DW-1 -: 2]};
    t  = {1'b0, p.root, 2'b01};
    r.n = p.n << 2;
    if (r2 >= t) begin
      r.rem  = (DW+2)'(r2 - t);
      r.root = {p.root[DW-2:0], 1'b1};
    end else begin
      r.rem  = r2[DW+1:0];
      r.root = {p.root[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Load |a_i| * 2^FB as dividend; the top part is already below the root
  function automatic pipe_t div_init(input pipe_t p);
    pipe_t         r;
    logic [DW-1:0] mag;
    r = p;
    for (int i = 0; i < 3; i++) begin
      mag       = p.a[i][DW-1] ? DW'(-p.a[i]) : DW'(p.a[i]);
      r.drem[i] = {2'b00, mag[DW-1:2]};
      r.dn[i]   = {mag[1:0], {FB{1'b0}}};
      r.dq[i]   = '0;
    end
    return r;
  endfunction

  // One restoring-divide bit per component, divisor is the root
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       r;
    logic [DW:0] r2;
    r = p;
    for (int i = 0; i < 3; i++) begin
      r2      = {p.drem[i], p.dn[i][DQ_W-1]};
      r.dn[i] = p.dn[i] << 1;
      if (r2 >= {1'b0, p.root}) begin
        r.drem[i] = DW'(r2 - {1'b0, p.root});
        r.dq[i]   = {p.dq[i][DQ_W-2:0], 1'b1};
      end else begin
        r.drem[i] = r2[DW-1:0];
        r.dq[i]   = {p.dq[i][DQ_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // Stage 1: select multiplier operands
  fx_t  ra [3];
  fx_t  rb [3];
  fx_t  selx [6];
  fx_t  sely [6];
  logic v1;
  req_t d1;
  fx_t  x1 [6];
  fx_t  y1 [6];

  always_comb begin
    ra = '{req.a_x, req.a_y, req.a_z};
    rb = '{req.b_x, req.b_y, req.b_z};
    for (int i = 0; i < 3; i++) begin
      selx[i]   = ra[i];
      sely[i]   = rb[i];
      selx[i+3] = '0;
      sely[i+3] = '0;
    end
    case (req.operation)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) sely[i] = req.scale_factor;
      end
      OP_CROSS: begin
        selx[0] = ra[1]; sely[0] = rb[2];
        selx[1] = ra[2]; sely[1] = rb[1];
        selx[2] = ra[2]; sely[2] = rb[0];
        selx[3] = ra[0]; sely[3] = rb[2];
        selx[4] = ra[0]; sely[4] = rb[1];
        selx[5] = ra[1]; sely[5] = rb[0];
      end
      OP_NORMALIZE, OP_LENGTH: begin
        for (int i = 0; i < 3; i++) sely[i] = ra[i];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= req;
      x1 <= selx;
      y1 <= sely;
    end
  end

  // Stage 2: multiply, and add, subtract or clamp
  fx_t                    a1 [3];
  fx_t                    b1 [3];
  logic signed [DW:0]     t1;
  fx_t                    m1;
  satv_t                  s1;
  fx_t [2:0]              ev;
  logic                   ef;
  logic signed [2*DW-1:0] pm [6];

  logic                   v2;
  logic [OP_W-1:0]        op2;
  fx_t [2:0]              a2;
  fx_t [2:0]              ev2;
  logic                   ef2;
  logic signed [2*DW-1:0] p2 [6];

  always_comb begin
    a1 = '{d1.a_x, d1.a_y, d1.a_z};
    b1 = '{d1.b_x, d1.b_y, d1.b_z};
    ev = '0;
    ef = 1'b0;
    t1 = '0;
    m1 = '0;
    s1 = '0;
    for (int k = 0; k < 6; k++) pm[k] = x1[k] * y1[k];
    for (int i = 0; i < 3; i++) begin
      case (d1.operation)
        OP_ADD: begin
          t1    = (DW+1)'(a1[i]) + (DW+1)'(b1[i]);
          s1    = fx_sat(SAT_W'(t1));
          ev[i] = s1.val;
          ef    = ef | s1.sat;
        end
        OP_SUB: begin
          t1    = (DW+1)'(a1[i]) - (DW+1)'(b1[i]);
          s1    = fx_sat(SAT_W'(t1));
          ev[i] = s1.val;
          ef    = ef | s1.sat;
        end
        OP_CLAMP: begin
          m1    = (a1[i] < d1.clamp_high) ? a1[i] : d1.clamp_high;
          ev[i] = (m1 > d1.clamp_low) ? m1 : d1.clamp_low;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= d1.operation;
      a2  <= {d1.a_z, d1.a_y, d1.a_x};
      ev2 <= ev;
      ef2 <= ef;
      p2  <= pm;
    end
  end

  // Stage 3: reduce products, form the sum of squares
  pipe_t                  c3;
  logic signed [SAT_W-1:0] wsum [3];
  satv_t                  sv [3];

  always_comb begin
    c3      = '0;
    c3.op   = op2;
    c3.a    = a2;
    c3.n    = $unsigned(p2[0]) + $unsigned(p2[1]) + $unsigned(p2[2]);
    for (int i = 0; i < 3; i++) begin
      wsum[i] = SAT_W'(p2[i] >>> FB);
    end
    case (op2)
      OP_CROSS: begin
        wsum[0] = (SAT_W'(p2[0]) - SAT_W'(p2[1])) >>> FB;
        wsum[1] = (SAT_W'(p2[2]) - SAT_W'(p2[3])) >>> FB;
        wsum[2] = (SAT_W'(p2[4]) - SAT_W'(p2[5])) >>> FB;
      end
      OP_DOT: begin
        wsum[0] = (SAT_W'(p2[0]) + SAT_W'(p2[1]) + SAT_W'(p2[2])) >>> FB;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) sv[i] = fx_sat(wsum[i]);
    case (op2)
      OP_ADD, OP_SUB, OP_CLAMP: begin
        c3.res.result_x  = ev2[0];
        c3.res.result_y  = ev2[1];
        c3.res.result_z  = ev2[2];
        c3.res.saturated = ef2;
      end
      OP_SCALE, OP_MUL, OP_CROSS: begin
        c3.res.result_x  = sv[0].val;
        c3.res.result_y  = sv[1].val;
        c3.res.result_z  = sv[2].val;
        c3.res.saturated = sv[0].sat | sv[1].sat | sv[2].sat;
      end
      OP_DOT: begin
        c3.res.result_scalar = sv[0].val;
        c3.res.saturated     = sv[0].sat;
      end
      default: begin
      end
    endcase
  end

  // Stages 4 onward: square root, then divide
  pipe_t            pl [NPL];
  logic [NPL-1:0]   pv;

  always_ff @(posedge clk) begin
    if (en) begin
      pl[0] <= c3;
    end
  end

  for (genvar k = 1; k < NPL; k++) begin : g_stage
    pipe_t nxt;
    always_comb begin
      nxt = pl[k-1];
      if (k <= SQ_STG) begin
        nxt = sqrt_step(sqrt_step(nxt));
      end else begin
        if (k == SQ_STG + 1) nxt = div_init(nxt);
        nxt = div_step(div_step(nxt));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pl[k] <= nxt;
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      pv        <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v1        <= req_valid;
      v2        <= v1;
      pv        <= {pv[NPL-2:0], v2};
      rsp_valid <= pv[NPL-1];
    end
  end

  // Output stage: apply sign to quotients, limit the length
  pipe_t           f;
  rsp_t            fin;
  fx_t             qv;
  fx_t             nv [3];
  logic [OP_W-1:0] rsp_op;

  always_comb begin
    f   = pl[NPL-1];
    fin = f.res;
    qv  = '0;
    for (int i = 0; i < 3; i++) begin
      qv    = fx_t'(DW'(f.dq[i]));
      nv[i] = f.a[i][DW-1] ? -qv : qv;
    end
    if (f.op == OP_NORMALIZE && f.root != '0) begin
      fin.result_x = nv[0];
      fin.result_y = nv[1];
      fin.result_z = nv[2];
    end
    if (f.op == OP_LENGTH) begin
      fin.result_scalar = f.root[DW-1] ? FX_MAX : fx_t'(f.root);
      fin.saturated     = f.root[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp    <= fin;
      rsp_op <= f.op;
    end
  end

  // Scalar operations leave the vector at zero
  a_scalar_ops_zero_vec: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_op == OP_DOT || rsp_op == OP_LENGTH) |->
      rsp.result_x == '0 && rsp.result_y == '0 && rsp.result_z == '0)
    else $error("vector result not zero for scalar operation");

  // Vector operations leave the scalar at zero
  a_vec_ops_zero_scalar: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_op != OP_DOT && rsp_op != OP_LENGTH |->
      rsp.result_scalar == '0)
    else $error("scalar result not zero for vector operation");

  // A unit vector never needs limiting
  a_norm_no_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_op == OP_NORMALIZE |-> !rsp.saturated)
    else $error("normalize result saturated");

  // A stall freezes every valid bit in the pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> pv == $past(pv) && v1 == $past(v1) && v2 == $past(v2))
    else $error("pipeline moved during stall");

endmodule

@@ tb/sv/vector3_arithmetic_unit_tb.sv @@
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_tb
// Self-checking bench for the Q16.16 vector unit: directed corner items for
// every operation, then random items under several handshake idling phases,
// each result checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;
  import v3alu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  rsp_t expected_rsp_q[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_off = 1'b0;

  vector3_arithmetic_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Generate the clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Signed wide values used by the predictor
  typedef logic signed [127:0] wide_t;

  function automatic wide_t floor_frac(input wide_t p);
    return p >>> FB;
  endfunction

  function automatic fx_t limit_fx(input wide_t v, inout logic flag);
    if (v > wide_t'(FX_MAX)) begin
      flag = 1'b1;
      return FX_MAX;
    end
    if (v < wide_t'(FX_MIN)) begin
      flag = 1'b1;
      return FX_MIN;
    end
    return fx_t'(v[DW-1:0]);
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] bitv;
    r = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r[63:0];
  endfunction

  // Predict the unit's response to one request
  function automatic rsp_t vector_result(input req_t q);
    rsp_t  o;
    wide_t a[3];
    wide_t b[3];
    wide_t v[3];
    wide_t sq;
    wide_t len;
    wide_t sc;
    wide_t lo;
    wide_t hi;
    logic  flag;
    flag = 1'b0;
    o = '0;
    a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
    b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
    lo = q.clamp_low;
    hi = q.clamp_high;
    sc = q.scale_factor;
    case (q.operation)
      OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) v[i] = floor_frac(a[i] * sc);
      OP_MUL: for (int i = 0; i < 3; i++) v[i] = floor_frac(a[i] * b[i]);
      OP_CROSS: begin
        v[0] = floor_frac(a[1] * b[2] - a[2] * b[1]);
        v[1] = floor_frac(a[2] * b[0] - a[0] * b[2]);
        v[2] = floor_frac(a[0] * b[1] - a[1] * b[0]);
      end
      OP_CLAMP: begin
        for (int i = 0; i < 3; i++) begin
          v[i] = (a[i] < hi) ? a[i] : hi;
          if (lo > v[i]) v[i] = lo;
        end
      end
      default: for (int i = 0; i < 3; i++) v[i] = 0;
    endcase
    if (q.operation == OP_DOT) begin
      o.result_scalar = limit_fx(floor_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]),
                                 flag);
    end else if (q.operation == OP_LENGTH || q.operation == OP_NORMALIZE) begin
      sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      len = wide_t'(root_floor(sq));
      if (q.operation == OP_LENGTH) begin
        o.result_scalar = limit_fx(len, flag);
      end else if (len != 0) begin
        o.result_x = limit_fx((a[0] <<< FB) / len, flag);
        o.result_y = limit_fx((a[1] <<< FB) / len, flag);
        o.result_z = limit_fx((a[2] <<< FB) / len, flag);
      end
    end else if (q.operation <= OP_LENGTH) begin
      o.result_x = limit_fx(v[0], flag);
      o.result_y = limit_fx(v[1], flag);
      o.result_z = limit_fx(v[2], flag);
    end
    o.saturated = flag;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Check each response transfer against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", rsp.result_x, 32'd0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.result_x !== want.result_x) report_mismatch("result_x", rsp.result_x,
                                                            want.result_x);
        if (rsp.result_y !== want.result_y) report_mismatch("result_y", rsp.result_y,
                                                            want.result_y);
        if (rsp.result_z !== want.result_z) report_mismatch("result_z", rsp.result_z,
                                                            want.result_z);
        if (rsp.result_scalar !== want.result_scalar)
          report_mismatch("result_scalar", rsp.result_scalar, want.result_scalar);
        if (rsp.saturated !== want.saturated)
          report_mismatch("saturated", rsp.saturated, want.saturated);
      end
    end
  end

  // Drive rsp_ready: random stalls, or held low during a hold-off
  always @(negedge clk) begin
    if (hold_off) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_rsp_q.push_back(vector_result(q));
    @(negedge clk);
  endtask

  function automatic fx_t rand_fx();
    case ($urandom_range(5))
      0: return fx_t'($urandom);
      1: return fx_t'($signed($urandom_range(65536 * 8)) - 65536 * 4);
      2: return ($urandom_range(1)) ? FX_MAX : FX_MIN;
      3: return fx_t'($signed($urandom_range(255)) - 128);
      default: return fx_t'($signed($urandom_range(32'h0100_0000)) - 32'h0080_0000);
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t q;
    q.operation = ($urandom_range(19) == 0) ? OP_W'($urandom_range(15, 9))
                                            : OP_W'($urandom_range(8));
    q.a_x = rand_fx(); q.a_y = rand_fx(); q.a_z = rand_fx();
    q.b_x = rand_fx(); q.b_y = rand_fx(); q.b_z = rand_fx();
    q.scale_factor = rand_fx();
    q.clamp_low = rand_fx();
    q.clamp_high = rand_fx();
    if (q.operation == OP_NORMALIZE && $urandom_range(9) == 0) begin
      q.a_x = '0; q.a_y = '0; q.a_z = '0;
    end
    return q;
  endfunction

  // Drop valid, wait for every outstanding result, resume on a falling edge
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes, every operation and the special cases
  task automatic test_directed();
    req_t q;
    for (int op = 0; op < 9; op++) begin
      q = '0;
      q.operation = OP_W'(op);
      q.a_x = FX_MAX; q.a_y = FX_MIN; q.a_z = 32'sh0001_8000;
      q.b_x = FX_MAX; q.b_y = FX_MAX; q.b_z = FX_MIN;
      q.scale_factor = FX_MIN;
      q.clamp_low = -32'sh0001_0000;
      q.clamp_high = 32'sh0001_0000;
      send_request(q);
      q.a_x = 32'sh0003_0000; q.a_y = -32'sh0004_0000; q.a_z = -32'sd1;
      q.b_x = -32'sd1; q.b_y = 32'sh0000_8000; q.b_z = 32'sh0002_0000;
      q.scale_factor = 32'sh0000_4000;
      send_request(q);
    end
    // zero-length normalize
    q = '0;
    q.operation = OP_NORMALIZE;
    send_request(q);
    // crossed clamp bounds
    q.operation = OP_CLAMP;
    q.a_x = FX_MIN; q.a_y = FX_MAX; q.a_z = '0;
    q.clamp_low = 32'sh0005_0000;
    q.clamp_high = -32'sh0005_0000;
    send_request(q);
    // unused operation codes
    q.operation = 4'hF;
    q.a_x = FX_MAX; q.b_x = FX_MAX;
    send_request(q);
    q.operation = 4'h9;
    send_request(q);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(rand_request());
    wait_drained();
  endtask

  // Hold off the receiver while requests keep coming, so the pipe backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (80) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (60) send_request(rand_request());
    join
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 49, 0);
    test_random(200, 0, 49);
    test_random(200, 7, 7);
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ vector3_arithmetic_unit.f @@
sv/v3alu_pkg.sv
sv/vector3_arithmetic_unit.sv
tb/sv/vector3_arithmetic_unit_tb.sv
